/* design/pesr_pkg.sv */
// ---------------------------------------------------------------------------
// pesr_pkg: shared constants and helpers for the equal-spacing resampler
// Widths, register indexes and the output saturation function.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pesr_pkg;

    // points returned per input vertex at most
    localparam int MAX_POINTS_PER_VERTEX = 64;
    localparam int CNT_W   = $clog2(MAX_POINTS_PER_VERTEX + 1);

    localparam int COORD_W = 24;   // coordinates
    localparam int MAG_W   = 25;   // |difference| of two coordinates
    localparam int LEN_W   = 25;   // segment length
    localparam int PROD_W  = 50;   // shared multiplier product
    localparam int NUM_W   = 42;   // divider dividend / quotient
    localparam int Q_W     = 26;   // interpolation accumulators
    localparam int SP_W    = 16;   // spacing and carried distance
    localparam int EXT_W   = 28;   // point arithmetic before saturation

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACING  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_X = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_Y = 2'd2;

    localparam logic [SP_W-1:0] SPACING_RESET = 16'd5120;

    // clamp to the signed 24 bit range
    function automatic logic signed [COORD_W-1:0] sat24(input logic signed [EXT_W-1:0] v);
        logic signed [COORD_W-1:0] r;
        if (v < -28'sd8388608) begin
            r = 24'sh800000;
        end else if (v > 28'sd8388607) begin
            r = 24'sh7FFFFF;
        end else begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

/* design/pesr_if.sv */
// ---------------------------------------------------------------------------
// pesr_vtx_if / pesr_smp_if: valid/ready channels of the resampler
// Vertex input channel and sample output channel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pesr_vtx_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [pesr_pkg::COORD_W-1:0]    vertex_x;
    logic signed [pesr_pkg::COORD_W-1:0]    vertex_y;
    logic                                   begins_figure;
    logic                                   closes_figure;

    modport source (output valid, vertex_x, vertex_y, begins_figure, closes_figure,
                    input ready);
    modport sink   (input valid, vertex_x, vertex_y, begins_figure, closes_figure,
                    output ready);
endinterface

interface pesr_smp_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [pesr_pkg::COORD_W-1:0]    sample_x;
    logic signed [pesr_pkg::COORD_W-1:0]    sample_y;
    logic                                   final_of_run;
    logic                                   overflowed;

    modport source (output valid, sample_x, sample_y, final_of_run, overflowed,
                    input ready);
    modport sink   (input valid, sample_x, sample_y, final_of_run, overflowed,
                    output ready);
endinterface

/* design/pesr_sqrt.sv */
// ---------------------------------------------------------------------------
// pesr_sqrt: iterative integer square root
// Digit-by-digit floor square root, one root bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pesr_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [pesr_pkg::PROD_W-1:0]   i_rad,
    output logic                          o_done,
    output logic [pesr_pkg::LEN_W-1:0]    o_root
);
    localparam int REM_W = pesr_pkg::LEN_W + 4;

    logic                          r_busy;
    logic                          r_done;
    logic [4:0]                    r_cnt;
    logic [pesr_pkg::PROD_W-1:0]   r_rad;
    logic [REM_W-1:0]              r_rem;
    logic [pesr_pkg::LEN_W-1:0]    r_root;

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             ge;

    // one root bit: bring down two radicand bits, try 4*root+1
    assign rem_sh = {r_rem[REM_W-3:0], r_rad[pesr_pkg::PROD_W-1 -: 2]};
    assign trial  = {2'b00, r_root, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(pesr_pkg::LEN_W - 1);
                r_rad  <= i_rad;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_rad  <= {r_rad[pesr_pkg::PROD_W-3:0], 2'b00};
                r_rem  <= ge ? (rem_sh - trial) : rem_sh;
                r_root <= {r_root[pesr_pkg::LEN_W-2:0], ge};
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 5'd1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

/* design/pesr_div.sv */
// ---------------------------------------------------------------------------
// pesr_div: iterative restoring divider
// Unsigned divide, one quotient bit per cycle, shared by the sequencer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pesr_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [pesr_pkg::NUM_W-1:0]    i_num,
    input  logic [pesr_pkg::LEN_W-1:0]    i_den,
    output logic                          o_done,
    output logic [pesr_pkg::NUM_W-1:0]    o_quot,
    output logic [pesr_pkg::LEN_W-1:0]    o_rem
);
    logic                          r_busy;
    logic                          r_done;
    logic [5:0]                    r_cnt;
    logic [pesr_pkg::NUM_W-1:0]    r_q;
    logic [pesr_pkg::LEN_W-1:0]    r_rem;
    logic [pesr_pkg::LEN_W-1:0]    r_den;

    logic [pesr_pkg::LEN_W:0] sh;
    logic [pesr_pkg::LEN_W:0] diff;
    logic                     ge;

    // shift in the next dividend bit and try a subtract
    assign sh   = {r_rem, r_q[pesr_pkg::NUM_W-1]};
    assign ge   = (sh >= {1'b0, r_den});
    assign diff = sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(pesr_pkg::NUM_W - 1);
                r_q    <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_q   <= {r_q[pesr_pkg::NUM_W-2:0], ge};
                r_rem <= ge ? diff[pesr_pkg::LEN_W-1:0] : sh[pesr_pkg::LEN_W-1:0];
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 6'd1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;

endmodule

/* design/polyline_equal_spacing_resampler.sv */
// Timing: a figure-start vertex passes S_BEGIN_CLOSE and S_FINISH; each walked
// segment runs a square root and five divisions in the shared divider, with
// multiplier waits, and then emits its points.
// Throughput: one vertex at a time; input ready only while the sequencer idles.
// Reset: synchronous active-low; clears state, spacing 5120, centre zero.
// ---------------------------------------------------------------------------
// polyline_equal_spacing_resampler: arc-length resampler of outline figures
// Walks each segment and emits points at equal arc-length spacing, offset by
// the configured centre, with a last-point and a dropped-points flag.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module polyline_equal_spacing_resampler (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [pesr_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pesr_pkg::COORD_W-1:0]      i_cfg_data,
    pesr_vtx_if.sink                          i_vtx,
    pesr_smp_if.source                        o_smp
);
    typedef enum logic [4:0] {
        S_IDLE, S_BEGIN_CLOSE, S_SEG_D, S_SQ1, S_SQ2, S_SQ3, S_SQ4,
        S_SQRT, S_SQRT_W, S_LEN, S_CNT_W, S_COEF_MUL, S_COEF_MW,
        S_COEF_DIV, S_COEF_DW, S_EMIT, S_SEG_END, S_FINISH
    } t_state;

    localparam int CW = pesr_pkg::COORD_W;
    localparam int QW = pesr_pkg::Q_W;
    localparam int EW = pesr_pkg::EXT_W;

    t_state r_state;

    // configuration
    logic [pesr_pkg::SP_W-1:0]  r_spacing;
    logic signed [CW-1:0]       r_centre_x, r_centre_y;

    // walk state
    logic signed [CW-1:0]       r_prev_x, r_prev_y, r_first_x, r_first_y;
    logic signed [CW-1:0]       r_tgt_x, r_tgt_y;
    logic [pesr_pkg::SP_W-1:0]  r_carry;
    logic                       r_closes, r_in_close;

    // segment arithmetic
    logic                          r_neg_x, r_neg_y;
    logic [pesr_pkg::MAG_W-1:0]    r_mx, r_my;
    logic [pesr_pkg::MAG_W-1:0]    r_ma, r_mb;
    logic [pesr_pkg::PROD_W-1:0]   r_prod, r_sum;
    logic [pesr_pkg::LEN_W-1:0]    r_len;
    logic [pesr_pkg::SP_W-1:0]     r_pos;
    logic                          r_axis, r_phase;
    logic [QW-1:0]                 r_qx, r_rx, r_inc_qx, r_inc_rx;
    logic [QW-1:0]                 r_qy, r_ry, r_inc_qy, r_inc_ry;
    logic [QW-1:0]                 r_left;
    logic [pesr_pkg::CNT_W-1:0]    r_cnt;
    logic                          r_dropped;

    // one pending point, so the last one of a run can be flagged
    logic                          r_pend_v;
    logic signed [CW-1:0]          r_pend_x, r_pend_y;

    // output register
    logic                          r_out_valid, r_out_final, r_out_ovf;
    logic signed [CW-1:0]          r_out_x, r_out_y;

    // shared units
    logic                          sqrt_start, sqrt_done;
    logic [pesr_pkg::LEN_W-1:0]    sqrt_root;
    logic                          div_start, div_done;
    logic [pesr_pkg::NUM_W-1:0]    div_num, div_quot;
    logic [pesr_pkg::LEN_W-1:0]    div_den, div_rem;

    logic [pesr_pkg::SP_W-1:0]     sp_eff, pos_c;
    logic signed [pesr_pkg::MAG_W-1:0] dx_c, dy_c;
    logic                          out_free;
    logic                          out_load;
    logic [pesr_pkg::CNT_W-1:0]    room;
    logic [QW-1:0]                 n_c;
    logic signed [EW-1:0]          ox_c, oy_c;
    logic signed [CW-1:0]          pt_x, pt_y, bx_c, by_c;
    logic [QW-1:0]                 rsx, rsy, nrx, nry, nqx, nqy;

    assign sp_eff   = (r_spacing == '0) ? 16'd1 : r_spacing;
    assign pos_c    = (sp_eff > r_carry) ? (sp_eff - r_carry) : '0;
    assign dx_c     = {r_tgt_x[CW-1], r_tgt_x} - {r_prev_x[CW-1], r_prev_x};
    assign dy_c     = {r_tgt_y[CW-1], r_tgt_y} - {r_prev_y[CW-1], r_prev_y};
    assign out_free = !r_out_valid || o_smp.ready;
    assign room     = pesr_pkg::CNT_W'(pesr_pkg::MAX_POINTS_PER_VERTEX) - r_cnt;
    assign n_c      = {1'b0, div_quot[QW-2:0]} + QW'(1);

    // held point moves to the output register this cycle
    assign out_load = out_free && r_pend_v &&
                      (((r_state == S_EMIT) && (r_left != '0) &&
                        (r_cnt < pesr_pkg::CNT_W'(pesr_pkg::MAX_POINTS_PER_VERTEX)))
                       || (r_state == S_FINISH));

    // point on the segment, centred and clamped
    assign ox_c = EW'(r_prev_x) + (r_neg_x ? -EW'(r_qx) : EW'(r_qx)) - EW'(r_centre_x);
    assign oy_c = EW'(r_prev_y) + (r_neg_y ? -EW'(r_qy) : EW'(r_qy)) - EW'(r_centre_y);
    assign pt_x = pesr_pkg::sat24(ox_c);
    assign pt_y = pesr_pkg::sat24(oy_c);
    assign bx_c = pesr_pkg::sat24(EW'(i_vtx.vertex_x) - EW'(r_centre_x));
    assign by_c = pesr_pkg::sat24(EW'(i_vtx.vertex_y) - EW'(r_centre_y));

    // step to the next point: quotient plus increment, remainder wrap at len
    assign rsx = r_rx + r_inc_rx;
    assign rsy = r_ry + r_inc_ry;
    assign nrx = (rsx >= QW'(r_len)) ? rsx - QW'(r_len) : rsx;
    assign nry = (rsy >= QW'(r_len)) ? rsy - QW'(r_len) : rsy;
    assign nqx = r_qx + r_inc_qx + QW'(rsx >= QW'(r_len));
    assign nqy = r_qy + r_inc_qy + QW'(rsy >= QW'(r_len));

    // shared unit control
    assign sqrt_start = (r_state == S_SQRT);
    assign div_start  = ((r_state == S_LEN) && (QW'(pos_c) <= QW'(r_len)))
                        || (r_state == S_COEF_DIV);
    always_comb begin
        if (r_state == S_LEN) begin
            div_num = pesr_pkg::NUM_W'(r_len - pesr_pkg::LEN_W'(pos_c));
            div_den = pesr_pkg::LEN_W'(sp_eff);
        end else begin
            div_num = r_prod[pesr_pkg::NUM_W-1:0]
                      + (r_phase ? '0 : pesr_pkg::NUM_W'(r_len[pesr_pkg::LEN_W-1:1]));
            div_den = r_len;
        end
    end

    pesr_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_rad   (r_sum),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    pesr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot),
        .o_rem   (div_rem)
    );

    // shared multiplier, registered
    always_ff @(posedge i_clk) begin
        r_prod <= r_ma * r_mb;
    end

    // sequencer, configuration and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_spacing   <= pesr_pkg::SPACING_RESET;
            r_centre_x  <= '0;
            r_centre_y  <= '0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_first_x   <= '0;
            r_first_y   <= '0;
            r_carry     <= '0;
            r_pend_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pesr_pkg::CFG_SPACING:  r_spacing  <= i_cfg_data[pesr_pkg::SP_W-1:0];
                    pesr_pkg::CFG_CENTRE_X: r_centre_x <= i_cfg_data;
                    pesr_pkg::CFG_CENTRE_Y: r_centre_y <= i_cfg_data;
                    default: ;
                endcase
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_smp.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_vtx.valid) begin
                        r_closes   <= i_vtx.closes_figure;
                        r_in_close <= 1'b0;
                        r_dropped  <= 1'b0;
                        r_tgt_x    <= i_vtx.vertex_x;
                        r_tgt_y    <= i_vtx.vertex_y;
                        if (i_vtx.begins_figure) begin
                            r_first_x <= i_vtx.vertex_x;
                            r_first_y <= i_vtx.vertex_y;
                            r_prev_x  <= i_vtx.vertex_x;
                            r_prev_y  <= i_vtx.vertex_y;
                            r_carry   <= '0;
                            r_pend_v  <= 1'b1;
                            r_pend_x  <= bx_c;
                            r_pend_y  <= by_c;
                            r_cnt     <= pesr_pkg::CNT_W'(1);
                            r_state   <= S_BEGIN_CLOSE;
                        end else begin
                            r_cnt   <= '0;
                            r_state <= S_SEG_D;
                        end
                    end
                end
                // a start vertex walks no segment, even if it also closes the figure
                S_BEGIN_CLOSE: begin
                    r_state <= S_FINISH;
                end
                S_SEG_D: begin
                    r_neg_x <= dx_c[pesr_pkg::MAG_W-1];
                    r_neg_y <= dy_c[pesr_pkg::MAG_W-1];
                    r_mx    <= dx_c[pesr_pkg::MAG_W-1] ? -dx_c : dx_c;
                    r_my    <= dy_c[pesr_pkg::MAG_W-1] ? -dy_c : dy_c;
                    r_state <= S_SQ1;
                end
                S_SQ1: begin
                    r_ma    <= r_mx;
                    r_mb    <= r_mx;
                    r_state <= S_SQ2;
                end
                S_SQ2: begin
                    r_ma    <= r_my;
                    r_mb    <= r_my;
                    r_state <= S_SQ3;
                end
                S_SQ3: begin
                    r_sum   <= r_prod;
                    r_state <= S_SQ4;
                end
                S_SQ4: begin
                    r_sum   <= r_sum + r_prod;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    r_state <= S_SQRT_W;
                end
                S_SQRT_W: begin
                    if (sqrt_done) begin
                        r_len <= sqrt_root;
                        if (sqrt_root == '0) begin
                            r_state <= S_SEG_END;
                        end else begin
                            r_state <= S_LEN;
                        end
                    end
                end
                // first point position; short segments only add to the carry
                S_LEN: begin
                    r_pos <= pos_c;
                    if (QW'(pos_c) > QW'(r_len)) begin
                        r_carry <= r_carry + r_len[pesr_pkg::SP_W-1:0];
                        r_state <= S_SEG_END;
                    end else begin
                        r_state <= S_CNT_W;
                    end
                end
                S_CNT_W: begin
                    if (div_done) begin
                        r_left  <= n_c;
                        r_carry <= div_rem[pesr_pkg::SP_W-1:0];
                        if (n_c > QW'(room)) begin
                            r_dropped <= 1'b1;
                        end
                        r_axis  <= 1'b0;
                        r_phase <= 1'b0;
                        r_state <= S_COEF_MUL;
                    end
                end
                // start quotients and per-point increments for each axis
                S_COEF_MUL: begin
                    r_ma    <= r_axis ? r_my : r_mx;
                    r_mb    <= r_phase ? pesr_pkg::MAG_W'(sp_eff)
                                       : pesr_pkg::MAG_W'(r_pos);
                    r_state <= S_COEF_MW;
                end
                S_COEF_MW: begin
                    r_state <= S_COEF_DIV;
                end
                S_COEF_DIV: begin
                    r_state <= S_COEF_DW;
                end
                S_COEF_DW: begin
                    if (div_done) begin
                        case ({r_axis, r_phase})
                            2'b00: begin
                                r_qx <= div_quot[QW-1:0];
                                r_rx <= QW'(div_rem);
                            end
                            2'b01: begin
                                r_inc_qx <= div_quot[QW-1:0];
                                r_inc_rx <= QW'(div_rem);
                            end
                            2'b10: begin
                                r_qy <= div_quot[QW-1:0];
                                r_ry <= QW'(div_rem);
                            end
                            default: begin
                                r_inc_qy <= div_quot[QW-1:0];
                                r_inc_ry <= QW'(div_rem);
                            end
                        endcase
                        if (r_axis && r_phase) begin
                            r_state <= S_EMIT;
                        end else begin
                            r_axis  <= r_axis ^ r_phase;
                            r_phase <= !r_phase;
                            r_state <= S_COEF_MUL;
                        end
                    end
                end
                // one point per cycle while the output side keeps up
                S_EMIT: begin
                    if ((r_left != '0) &&
                        (r_cnt < pesr_pkg::CNT_W'(pesr_pkg::MAX_POINTS_PER_VERTEX))) begin
                        if (!r_pend_v || out_free) begin
                            if (r_pend_v) begin
                                r_out_x     <= r_pend_x;
                                r_out_y     <= r_pend_y;
                                r_out_final <= 1'b0;
                                r_out_ovf   <= 1'b0;
                            end
                            r_pend_v <= 1'b1;
                            r_pend_x <= pt_x;
                            r_pend_y <= pt_y;
                            r_qx     <= nqx;
                            r_rx     <= nrx;
                            r_qy     <= nqy;
                            r_ry     <= nry;
                            r_left   <= r_left - QW'(1);
                            r_cnt    <= r_cnt + pesr_pkg::CNT_W'(1);
                        end
                    end else begin
                        r_state <= S_SEG_END;
                    end
                end
                S_SEG_END: begin
                    r_prev_x <= r_tgt_x;
                    r_prev_y <= r_tgt_y;
                    if (r_closes && !r_in_close) begin
                        r_in_close <= 1'b1;
                        r_tgt_x    <= r_first_x;
                        r_tgt_y    <= r_first_y;
                        r_state    <= S_SEG_D;
                    end else begin
                        r_state <= S_FINISH;
                    end
                end
                // flush the held point as the last of the run
                S_FINISH: begin
                    if (!r_pend_v) begin
                        r_state <= S_IDLE;
                    end else if (out_free) begin
                        r_out_x     <= r_pend_x;
                        r_out_y     <= r_pend_y;
                        r_out_final <= 1'b1;
                        r_out_ovf   <= r_dropped;
                        r_pend_v    <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_vtx.ready        = (r_state == S_IDLE);
    assign o_smp.valid        = r_out_valid;
    assign o_smp.sample_x     = r_out_x;
    assign o_smp.sample_y     = r_out_y;
    assign o_smp.final_of_run = r_out_final;
    assign o_smp.overflowed   = r_out_ovf;

endmodule

/* design/pesr_checker.sv */
// ---------------------------------------------------------------------------
// pesr_checker: port-level checks of the resampler
// Watches the vertex and sample channels; bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pesr_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic                          i_out_final,
    input logic                          i_out_ovf,
    input logic [pesr_pkg::COORD_W-1:0]  i_out_x,
    input logic [pesr_pkg::COORD_W-1:0]  i_out_y
);
    // dropped-points flag only rides on the last point
    a_ovf_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ovf |-> i_out_final)
        else $error("overflowed without final_of_run");

    // a vertex in work blocks the input
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready right after a transaction");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("sample valid dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_x) && $stable(i_out_y)
                                        && $stable(i_out_final) && $stable(i_out_ovf))
        else $error("sample payload changed while stalled");

endmodule

bind polyline_equal_spacing_resampler pesr_checker u_pesr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_vtx.valid),
    .i_in_ready  (i_vtx.ready),
    .i_out_valid (o_smp.valid),
    .i_out_ready (o_smp.ready),
    .i_out_final (o_smp.final_of_run),
    .i_out_ovf   (o_smp.overflowed),
    .i_out_x     (o_smp.sample_x),
    .i_out_y     (o_smp.sample_y)
);
